>>> src/esr_pkg.sv
`default_nettype none
package esr_pkg;

    localparam logic [1:0] REQ_LOAD_IN  = 2'd0;
    localparam logic [1:0] REQ_LOAD_REC = 2'd1;
    localparam logic [1:0] REQ_SAMPLE   = 2'd2;
    localparam logic [1:0] REQ_START    = 2'd3;

    localparam logic CFG_LEAK_RATE = 1'b0;
    localparam logic CFG_WASHOUT   = 1'b1;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    // tanh samples at k/8 in Q1.15
    function automatic logic [15:0] tanh_entry(input logic [5:0] k);
        logic [15:0] v;
        case (k)
            6'd0:  v = 16'd0;     6'd1:  v = 16'd4075;  6'd2:  v = 16'd8026;
            6'd3:  v = 16'd11743; 6'd4:  v = 16'd15143; 6'd5:  v = 16'd18173;
            6'd6:  v = 16'd20813; 6'd7:  v = 16'd23066; 6'd8:  v = 16'd24956;
            6'd9:  v = 16'd26519; 6'd10: v = 16'd27797; 6'd11: v = 16'd28830;
            6'd12: v = 16'd29660; 6'd13: v = 16'd30322; 6'd14: v = 16'd30847;
            6'd15: v = 16'd31262; 6'd16: v = 16'd31589; 6'd17: v = 16'd31846;
            6'd18: v = 16'd32048; 6'd19: v = 16'd32206; 6'd20: v = 16'd32329;
            6'd21: v = 16'd32426; 6'd22: v = 16'd32501; 6'd23: v = 16'd32560;
            6'd24: v = 16'd32606; 6'd25: v = 16'd32642; 6'd26: v = 16'd32670;
            6'd27: v = 16'd32691; 6'd28: v = 16'd32708; 6'd29: v = 16'd32721;
            6'd30: v = 16'd32732; 6'd31: v = 16'd32740;
            default: v = 16'd32746;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> src/esr_ram.sv
`default_nettype none
module esr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> src/esr_activate.sv
`default_nettype none
// Two-stage tanh and leak mix: stage 1 interpolates, stage 2 mixes and clamps.
module esr_activate (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic signed [47:0] acc,
    input  wire logic signed [15:0] x_old,
    input  wire logic [16:0]        alpha,
    output logic                    out_valid,
    output logic signed [15:0]      out_value
);
    import esr_pkg::*;

    logic        neg;
    logic [47:0] mag;
    logic [15:0] y_lo, y_hi, y_abs;
    logic [14:0] frac;
    logic [31:0] prod;
    logic signed [16:0] t_c;

    logic               v1_reg;
    logic signed [16:0] t_reg;
    logic signed [15:0] x_reg;
    logic [16:0]        a_reg;

    logic signed [36:0] mix;
    logic signed [20:0] r;

    always_comb begin
        neg  = acc[47];
        mag  = neg ? 48'(-acc) : 48'(acc);
        frac = mag[23:9];
        y_lo = tanh_entry(mag[29:24]);
        y_hi = tanh_entry(mag[29:24] + 6'd1);
        prod = 32'(y_hi - y_lo) * 32'(frac);
        if (mag[47:29] != '0) begin
            y_abs = tanh_entry(6'd32);
        end else begin
            y_abs = y_lo + 16'(prod >> 15);
        end
        t_c = neg ? -$signed({1'b0, y_abs}) : $signed({1'b0, y_abs});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
        t_reg <= t_c;
        x_reg <= x_old;
        a_reg <= alpha;
        out_value <= r > 21'sd32767 ? 16'sd32767 :
                     r < -21'sd32768 ? -16'sd32768 : r[15:0];
    end

    always_comb begin
        mix = $signed({1'b0, a_reg}) * t_reg
            + $signed({1'b0, ALPHA_ONE - a_reg}) * x_reg + 37'sd32768;
        r = 21'(mix >>> 16);
    end
endmodule
`default_nettype wire

>>> src/echo_state_reservoir_update.sv
`default_nettype none
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    tdata {data,col,row}, tuser req, tlast slice_end
// m_axis    out  m_tvalid/m_tready    tdata {value,index}, tlast run_last
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
// Loads, starts and plain samples are taken back to back while idle.
// A slice end runs one MAC per weight of each row (only the input weights with echo off),
// accumulates, runs the activation, then copies the new state once all rows are done.
// Once the washout is over, results then leave in index order; a stall on m_tready holds them.
// s_tready stays low from slice end until the last result is taken, or the copy ends in washout.
// Reset is synchronous; weights and slice stay undefined, the state reads zero.
module echo_state_reservoir_update #(
    parameter int RES_SIZE = 64,
    parameter int IN_SIZE  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [5:0] row_index, [12:6] col_index, [28:13] data_value, [31:29] zero
    input  wire logic [31:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [5:0] state_index, [21:6] state_value, [23:22] zero
    output logic      [23:0] m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data
);
    import esr_pkg::*;

    localparam int IN_COLS = IN_SIZE + 1;
    localparam int RW = $clog2(RES_SIZE);
    localparam int IW = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
    localparam int WI_D = RES_SIZE * IN_COLS;
    localparam int WR_D = RES_SIZE * RES_SIZE;
    localparam int WIA = $clog2(WI_D);
    localparam int WRA = $clog2(WR_D);
    localparam int CW = $clog2(IN_COLS + RES_SIZE + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_MAC = 5'b00010, S_ACT = 5'b00100,
        S_COPY = 5'b01000, S_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    logic [1:0] req;
    logic [5:0] row;
    logic [6:0] col;
    logic signed [15:0] din;
    logic last, acc_in;
    assign req = s_tuser;
    assign row = s_tdata[5:0];
    assign col = s_tdata[12:6];
    assign din = s_tdata[28:13];
    assign last = s_tlast;
    assign s_tready = (state_reg == S_IDLE);
    assign acc_in = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    logic [16:0] leak_reg;
    logic [15:0] wash_reg, step_reg;
    logic [16:0] alpha;
    logic echo_reg;
    assign alpha = leak_reg > ALPHA_ONE ? ALPHA_ONE : leak_reg;

    logic [RES_SIZE-1:0] xv_reg;  // state entry valid since start
    logic [RW-1:0] i_reg;          // row
    logic [CW-1:0] j_reg;          // column in concatenated row, issued
    logic       pv_reg;            // RAM read data of the previous issue is valid now
    logic [CW-1:0] pj_reg;
    logic signed [47:0] acc_reg;
    logic emit_reg;
    logic [RW-1:0] e_reg;

    // memories
    logic wi_we, wr_we, u_we, x_we, n_we;
    logic [WIA-1:0] wi_ra; logic [WRA-1:0] wr_ra; logic [IW-1:0] u_ra;
    logic [RW-1:0] x_ra, x_wa, n_ra, n_wa;
    logic [15:0] wi_rd, wr_rd, u_rd, x_rd, n_rd, x_wd, n_wd;

    assign wi_we = acc_in && req == REQ_LOAD_IN && 32'(row) < RES_SIZE
                   && 32'(col) < IN_COLS;
    assign wr_we = acc_in && req == REQ_LOAD_REC && 32'(row) < RES_SIZE
                   && 32'(col) < RES_SIZE;
    assign u_we  = acc_in && req == REQ_SAMPLE && 32'(col) < IN_SIZE;

    esr_ram #(.WIDTH(16), .DEPTH(WI_D)) u_wi (.aclk, .we(wi_we),
        .waddr(WIA'(32'(row) * IN_COLS + 32'(col))), .wdata(din),
        .raddr(wi_ra), .rdata(wi_rd));
    esr_ram #(.WIDTH(16), .DEPTH(WR_D)) u_wr (.aclk, .we(wr_we),
        .waddr(WRA'(32'(row) * RES_SIZE + 32'(col))), .wdata(din),
        .raddr(wr_ra), .rdata(wr_rd));
    esr_ram #(.WIDTH(16), .DEPTH(IN_SIZE > 1 ? IN_SIZE : 2)) u_u (.aclk, .we(u_we),
        .waddr(IW'(col)), .wdata(din), .raddr(u_ra), .rdata(u_rd));
    esr_ram #(.WIDTH(16), .DEPTH(RES_SIZE)) u_x (.aclk, .we(x_we),
        .waddr(x_wa), .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));
    esr_ram #(.WIDTH(16), .DEPTH(RES_SIZE)) u_n (.aclk, .we(n_we),
        .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));

    logic [CW-1:0] row_len;
    assign row_len = echo_reg ? CW'(IN_COLS + RES_SIZE) : CW'(IN_COLS);
    logic issue;
    assign issue = (state_reg == S_MAC) && (j_reg < row_len);

    logic [CW-1:0] jr;
    always_comb begin
        jr = j_reg - CW'(IN_COLS);
        wi_ra = WIA'(32'(i_reg) * IN_COLS + 32'(j_reg));
        wr_ra = WRA'(32'(i_reg) * RES_SIZE + 32'(jr));
        u_ra  = IW'(j_reg - CW'(1));
        // outside recurrent issues, keep the own row's state ready for the activation
        x_ra  = (issue && j_reg >= CW'(IN_COLS)) ? RW'(jr) : i_reg;
        if (state_reg == S_COPY || state_reg == S_EMIT) x_ra = e_reg;
    end

    // product for the previous issue
    logic [RW-1:0] x_ra_q;
    logic signed [15:0] xs;
    logic signed [47:0] term;
    always_ff @(posedge aclk) x_ra_q <= x_ra;
    assign xs = xv_reg[x_ra_q] ? $signed(x_rd) : 16'sd0;
    always_comb begin
        if (pj_reg == '0) term = 48'(signed'(wi_rd)) <<< 15;
        else if (pj_reg < CW'(IN_COLS))
            term = 48'(32'(signed'(wi_rd)) * 32'(signed'(u_rd))) <<< 3;
        else term = 48'(32'(signed'(wr_rd)) * 32'(xs));
    end

    logic act_v; logic signed [15:0] act_q;
    logic act_busy_reg;
    logic act_start;
    assign act_start = (state_reg == S_ACT) && !pv_reg && !act_busy_reg;
    esr_activate u_act (.aclk, .aresetn, .in_valid(act_start),
        .acc(acc_reg), .x_old(xs), .alpha, .out_valid(act_v), .out_value(act_q));

    assign n_we = act_v;
    assign n_wa = i_reg;
    assign n_wd = act_q;
    assign n_ra = e_reg;
    assign x_we = (state_reg == S_COPY) && pv_reg;
    assign x_wa = RW'(pj_reg);
    assign x_wd = n_rd;

    // emission: read n buffer one ahead, load output when free
    logic em_load;
    logic em_pend_reg;
    logic [RW-1:0] em_idx_reg;
    assign em_load = (state_reg == S_EMIT) && em_pend_reg && (!m_tvalid || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; leak_reg <= 17'd32768; wash_reg <= '0;
            step_reg <= '0; xv_reg <= '0; pv_reg <= 1'b0; act_busy_reg <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_LEAK_RATE) leak_reg <= cfg_data;
                else wash_reg <= cfg_data[15:0];
            end
            pv_reg <= issue || (state_reg == S_COPY && e_reg <= RW'(RES_SIZE - 1)
                       && !(pv_reg && pj_reg == CW'(RES_SIZE - 1)));
            pj_reg <= (state_reg == S_COPY) ? CW'(e_reg) : j_reg;
            case (state_reg)
                S_IDLE: if (acc_in) begin
                    if (req == REQ_START) begin
                        xv_reg <= '0; step_reg <= '0;
                    end else if (req == REQ_SAMPLE && last) begin
                        echo_reg <= !(wash_reg == '0 && alpha == ALPHA_ONE);
                        emit_reg <= step_reg >= wash_reg;
                        if (step_reg != 16'hFFFF) step_reg <= step_reg + 16'd1;
                        i_reg <= '0; j_reg <= '0; acc_reg <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (pv_reg) acc_reg <= acc_reg + term;
                    if (issue) j_reg <= j_reg + CW'(1);
                    else if (!pv_reg) state_reg <= S_ACT;
                end
                S_ACT: begin
                    if (act_start) act_busy_reg <= 1'b1;
                    if (act_v) begin
                        act_busy_reg <= 1'b0;
                        acc_reg <= '0; j_reg <= '0;
                        if (32'(i_reg) == RES_SIZE - 1) begin
                            e_reg <= '0; state_reg <= S_COPY;
                        end else begin
                            i_reg <= i_reg + RW'(1); state_reg <= S_MAC;
                        end
                    end
                end
                S_COPY: begin
                    if (32'(e_reg) != RES_SIZE - 1) e_reg <= e_reg + RW'(1);
                    if (pv_reg && pj_reg == CW'(RES_SIZE - 1)) begin
                        xv_reg <= '1; e_reg <= '0;
                        state_reg <= emit_reg ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (em_load) begin
                        m_tvalid <= 1'b1;
                        if (32'(e_reg) != RES_SIZE - 1) e_reg <= e_reg + RW'(1);
                    end else if (m_tvalid && m_tready) begin
                        m_tvalid <= 1'b0;
                        if (m_tlast) state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_pend_reg <= 1'b0;
        end else if (state_reg == S_COPY) begin
            em_pend_reg <= 1'b0;
        end else if (state_reg == S_EMIT) begin
            if (!em_pend_reg && !(m_tvalid && m_tlast)) begin
                em_pend_reg <= 1'b1;
                em_idx_reg <= e_reg;
            end else if (em_load) begin
                em_pend_reg <= 1'b0;
            end
        end
        if (em_load) begin
            m_tdata <= {2'b00, n_rd, em_idx_reg};
            m_tlast <= (32'(em_idx_reg) == RES_SIZE - 1);
        end
    end

    a_issue_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> state_reg == S_MAC)
        else $error("issue outside MAC");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted during emission");
    a_act_in_act: assert property (@(posedge aclk) disable iff (!aresetn)
        act_v |-> state_reg == S_ACT)
        else $error("activation result outside ACT");
endmodule
`default_nettype wire
